// ----- hw/rtl/stkc_pkg.sv -----
`timescale 1ns / 1ps
package stkc_pkg;
    localparam int DEPTH_DEF = 1024;
    localparam int WORD_WIDTH_DEF = 32;
    localparam int OP_W = 3;
    localparam int POS_W = 10;
    localparam int ST_W = 3;

    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_POP  = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd2;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd3;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd4;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd5;
    localparam logic [OP_W-1:0] OP_RDT  = 3'd6;
    localparam logic [OP_W-1:0] OP_RDB  = 3'd7;

    localparam logic [ST_W-1:0] ST_OK    = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 3'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 3'd2;
    localparam logic [ST_W-1:0] ST_FEW   = 3'd3;
    localparam logic [ST_W-1:0] ST_DIV0  = 3'd4;
    localparam logic [ST_W-1:0] ST_FULL  = 3'd5;

    // datapath commands from the controller
    typedef struct packed {
        logic rd_en;      // read stack at rd_sel address
        logic rd_sel;     // 0: x/top-1 address, 1: y/top-2 address
        logic cap_x;      // latch read data as x
        logic cap_y;      // latch read data as y
        logic alu_go;     // compute / start divider
        logic wr_push;    // write push value at count
        logic wr_res;     // write result at count-2
    } stkc_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_zero;
    } stkc_sts_t;
endpackage

// ----- hw/rtl/stkc_ram.sv -----
`timescale 1ns / 1ps
module stkc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end
    assign rdata = rdata_reg;
endmodule

// ----- hw/rtl/stkc_datapath.sv -----
`timescale 1ns / 1ps
module stkc_datapath #(
    parameter int DEPTH = 1024,
    parameter int WORD_WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  stkc_pkg::stkc_cmd_t       cmd,
    input  logic [2:0]                op,
    input  logic [WORD_WIDTH-1:0]     push_value,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr_b,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr_push,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr_res,
    output stkc_pkg::stkc_sts_t       sts,
    output logic [WORD_WIDTH-1:0]     rd_data,
    output logic [WORD_WIDTH-1:0]     alu_res
);
    import stkc_pkg::*;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(WORD_WIDTH + 1);

    logic [WORD_WIDTH-1:0] x_reg, y_reg, res_reg;
    logic [WORD_WIDTH-1:0] q_reg, r_reg, d_reg, r_next, q_next;
    logic [WORD_WIDTH:0]   trial;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg, neg_reg, fix_reg;
    logic [WORD_WIDTH-1:0] ax, ay, sx;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [WORD_WIDTH-1:0] wdata;

    // single store, one write and one read port
    assign we    = cmd.wr_push | cmd.wr_res;
    assign waddr = cmd.wr_push ? wr_addr_push : wr_addr_res;
    assign wdata = cmd.wr_push ? push_value : alu_res;

    stkc_ram #(.WIDTH(WORD_WIDTH), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .re(cmd.rd_en), .raddr(cmd.rd_sel ? rd_addr_b : rd_addr_a), .rdata(rd_data)
    );

    // operand latches
    always_ff @(posedge aclk) begin
        if (cmd.cap_x) x_reg <= rd_data;
        if (cmd.cap_y) y_reg <= rd_data;
    end

    assign ax = x_reg[WORD_WIDTH-1] ? (~x_reg + 1'b1) : x_reg;
    assign ay = y_reg[WORD_WIDTH-1] ? (~y_reg + 1'b1) : y_reg;

    // restoring divider step: one quotient bit a cycle
    assign trial  = {r_reg, q_reg[WORD_WIDTH-1]} - {1'b0, d_reg};
    always_comb begin
        if (!trial[WORD_WIDTH]) begin
            r_next = trial[WORD_WIDTH-1:0];
            q_next = {q_reg[WORD_WIDTH-2:0], 1'b1};
        end else begin
            r_next = {r_reg[WORD_WIDTH-2:0], q_reg[WORD_WIDTH-1]};
            q_next = {q_reg[WORD_WIDTH-2:0], 1'b0};
        end
    end

    // floor correction: round magnitude up when signs differ and a remainder is left
    assign sx = fix_reg ? (q_reg + ((r_reg != '0) ? 1'b1 : 1'b0)) : q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (cmd.alu_go && op == OP_DIV && x_reg != '0) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(WORD_WIDTH);
            q_reg    <= ay;
            r_reg    <= '0;
            d_reg    <= ax;
            fix_reg  <= x_reg[WORD_WIDTH-1] ^ y_reg[WORD_WIDTH-1];
        end else if (busy_reg) begin
            q_reg   <= q_next;
            r_reg   <= r_next;
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) busy_reg <= 1'b0;
        end
    end

    // add, subtract, multiply registered once
    always_ff @(posedge aclk) begin
        if (cmd.alu_go) begin
            unique case (op)
                OP_ADD:  res_reg <= y_reg + x_reg;
                OP_SUB:  res_reg <= y_reg - x_reg;
                OP_MUL:  res_reg <= WORD_WIDTH'(y_reg * x_reg);
                default: res_reg <= '0;
            endcase
        end
    end

    assign alu_res = (op == OP_DIV) ? (fix_reg ? (~sx + 1'b1) : sx) : res_reg;
    assign sts.div_busy = busy_reg;
    assign sts.div_zero = (x_reg == '0);
endmodule

// ----- hw/rtl/stkc_ctrl.sv -----
`timescale 1ns / 1ps
module stkc_ctrl #(
    parameter int DEPTH = 1024
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                op_in,
    input  logic [9:0]                pos_in,
    output logic [2:0]                op,
    output stkc_pkg::stkc_cmd_t       cmd,
    input  stkc_pkg::stkc_sts_t       sts,
    output logic [$clog2(DEPTH)-1:0]  rd_addr_a,
    output logic [$clog2(DEPTH)-1:0]  rd_addr_b,
    output logic [$clog2(DEPTH)-1:0]  wr_addr_push,
    output logic [$clog2(DEPTH)-1:0]  wr_addr_res,
    output logic                      out_load,
    output logic                      out_use_rd,
    output logic                      out_use_alu,
    output logic [2:0]                out_status,
    output logic [$clog2(DEPTH):0]    out_fill,
    input  logic                      out_free
);
    import stkc_pkg::*;
    localparam int AW = $clog2(DEPTH);
    localparam int CNTW = AW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDX  = 3'd1;
    localparam logic [2:0] S_RDY  = 3'd2;
    localparam logic [2:0] S_ALU  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_WB   = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]      state_reg, state_next;
    logic [2:0]      op_reg;
    logic [9:0]      pos_reg;
    logic [CNTW-1:0] count_reg, count_next;
    logic [2:0]      st_reg, st_next;
    logic            use_rd_reg, use_rd_next, use_alu_reg, use_alu_next;
    logic [CNTW-1:0] pos_ext;
    logic            accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid & in_ready;
    assign op       = op_reg;
    assign pos_ext  = CNTW'(pos_reg);

    // addresses: rd_a is top, pop or read target; rd_b is the second entry
    always_comb begin
        unique case (op_reg)
            OP_RDT:  rd_addr_a = AW'(count_reg - 1'b1 - pos_ext);
            OP_RDB:  rd_addr_a = AW'(pos_ext);
            default: rd_addr_a = AW'(count_reg - 1'b1);
        endcase
    end
    assign rd_addr_b    = AW'(count_reg - 2'd2);
    assign wr_addr_push = AW'(count_reg);
    assign wr_addr_res  = AW'(count_reg - 2'd2);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        st_next      = st_reg;
        use_rd_next  = use_rd_reg;
        use_alu_next = use_alu_reg;
        cmd          = '0;
        out_load     = 1'b0;
        unique case (state_reg)
            S_IDLE: ;
            S_RDX: begin
                st_next = ST_OK;
                use_rd_next = 1'b0;
                use_alu_next = 1'b0;
                state_next = S_DONE;
                unique case (op_reg)
                    OP_PUSH: begin
                        if (count_reg >= CNTW'(DEPTH)) st_next = ST_FULL;
                        else begin
                            cmd.wr_push = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    OP_POP: begin
                        if (count_reg == '0) st_next = ST_EMPTY;
                        else begin
                            cmd.rd_en = 1'b1;
                            use_rd_next = 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    OP_RDT, OP_RDB: begin
                        if (count_reg == '0) st_next = ST_EMPTY;
                        else if (pos_ext >= count_reg) st_next = ST_RANGE;
                        else begin
                            cmd.rd_en = 1'b1;
                            use_rd_next = 1'b1;
                        end
                    end
                    default: begin
                        if (count_reg < CNTW'(2)) st_next = ST_FEW;
                        else begin
                            cmd.rd_en = 1'b1;
                            state_next = S_RDY;
                        end
                    end
                endcase
            end
            S_RDY: begin
                cmd.cap_x  = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = 1'b1;
                state_next = S_ALU;
            end
            S_ALU: begin
                cmd.cap_y  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.alu_go = 1'b1;
                if (op_reg == OP_DIV && sts.div_zero) begin
                    st_next = ST_DIV0;
                    count_next = count_reg - 2'd2;
                    state_next = S_DONE;
                end else state_next = S_WB;
            end
            S_WB: begin
                if (!sts.div_busy) begin
                    cmd.wr_res = 1'b1;
                    use_alu_next = 1'b1;
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (accept) state_next = S_RDX;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= op_in;
            pos_reg <= pos_in;
        end
        st_reg      <= st_next;
        use_rd_reg  <= use_rd_next;
        use_alu_reg <= use_alu_next;
    end

    assign out_use_rd  = use_rd_reg;
    assign out_use_alu = use_alu_reg;
    assign out_status  = st_reg;
    assign out_fill    = count_reg;

    ap_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNTW'(DEPTH)) else $error("fill above depth");
    ap_one: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wr_push && cmd.wr_res)) else $error("two writes");
    ap_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == S_RDX) else $error("no start");
endmodule

// ----- hw/rtl/stack_calculator.sv -----
`timescale 1ns / 1ps
// Stack calculator: a LIFO of DEPTH signed words with add, subtract,
// multiply and floor divide.
// s_axis carries one command word; m_axis returns one result word per
// command: result value, status and fill level after the command.
// Commands are processed one at a time; s_axis_tready is high only while
// the controller is idle. A new command may be taken while the previous
// result still waits in the output register.
// Push, pop and reads pass from the command state to the output register; add,
// subtract and multiply first read both operands, compute and write the result
// back; divide also waits until the radix-2 divider has finished.
// The result sits in an output register until m_axis_tready; while the
// receiver stalls, at most one further command is taken and it waits
// finished until the output register frees.
// Reset (aresetn low, synchronous) empties the stack and clears the
// output valid; the store itself is not cleared and needs no sweep.
module stack_calculator #(
    parameter int DEPTH = stkc_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = stkc_pkg::WORD_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] operation, [2+WORD_WIDTH:3] push_value, then position (10), zero pad
    input  logic [((WORD_WIDTH+13+7)/8)*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_value, then status (3), then fill_level, zero pad
    output logic [((WORD_WIDTH+3+$clog2(DEPTH)+1+7)/8)*8-1:0] m_axis_tdata
);
    import stkc_pkg::*;
    localparam int AW = $clog2(DEPTH);
    localparam int OW = ((WORD_WIDTH+3+AW+1+7)/8)*8;

    stkc_cmd_t cmd;
    stkc_sts_t sts;
    logic [2:0] op;
    logic [AW-1:0] ra, rb, wp, wr;
    logic [WORD_WIDTH-1:0] rd_data, alu_res;
    logic out_load, use_rd, use_alu;
    logic [2:0] st;
    logic [AW:0] fill;
    logic valid_reg;
    logic [OW-1:0] data_reg;
    logic [WORD_WIDTH-1:0] val;
    logic [WORD_WIDTH-1:0] push_reg;

    stkc_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .op_in(s_axis_tdata[2:0]), .pos_in(s_axis_tdata[WORD_WIDTH+12:WORD_WIDTH+3]),
        .op(op), .cmd(cmd), .sts(sts),
        .rd_addr_a(ra), .rd_addr_b(rb), .wr_addr_push(wp), .wr_addr_res(wr),
        .out_load(out_load), .out_use_rd(use_rd), .out_use_alu(use_alu),
        .out_status(st), .out_fill(fill), .out_free(!valid_reg)
    );

    // push value held from the accepted word
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) push_reg <= s_axis_tdata[WORD_WIDTH+2:3];
    end

    stkc_datapath #(.DEPTH(DEPTH), .WORD_WIDTH(WORD_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .op(op),
        .push_value(push_reg),
        .rd_addr_a(ra), .rd_addr_b(rb), .wr_addr_push(wp), .wr_addr_res(wr),
        .sts(sts), .rd_data(rd_data), .alu_res(alu_res)
    );

    assign val = use_rd ? rd_data : (use_alu ? alu_res : '0);

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_load) begin
            valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            valid_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (out_load) data_reg <= OW'({fill, st, val});
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import stkc_pkg::*;

    localparam int DEPTH = 1024;
    localparam int WW = 32;
    localparam int IN_W = ((WW + 13 + 7) / 8) * 8;
    localparam int OUT_W = ((WW + 3 + $clog2(DEPTH) + 1 + 7) / 8) * 8;
    localparam int CNT_W = $clog2(DEPTH) + 1;
    localparam int CYCLE_LIMIT = 5000000;

    typedef struct packed {
        logic [WW-1:0]    value;
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] fill;
    } calc_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    // predictor state
    logic [WW-1:0] model_stack [DEPTH];
    int unsigned model_count = 0;
    calc_result_t pending_results [$];
    int errors = 0;
    int words_sent = 0;
    int words_checked = 0;
    int cycles = 0;

    stack_calculator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // floor division on signed words
    function automatic logic [WW-1:0] floor_div(logic [WW-1:0] y, logic [WW-1:0] x);
        logic [WW-1:0] ua, ub, q, r;
        ua = y[WW-1] ? -y : y;
        ub = x[WW-1] ? -x : x;
        q = ua / ub;
        r = ua % ub;
        if (y[WW-1] ^ x[WW-1]) begin
            if (r != 0) q = q + 1;
            q = -q;
        end
        return q;
    endfunction

    // compute the expected result word and update the stack copy
    function automatic calc_result_t calc_predict(logic [OP_W-1:0] op, logic [WW-1:0] val,
                                                  logic [POS_W-1:0] pos);
        calc_result_t r;
        logic [WW-1:0] x, y;
        r.value = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH: begin
                if (model_count >= DEPTH) r.status = ST_FULL;
                else begin
                    model_stack[model_count] = val;
                    model_count++;
                end
            end
            OP_POP: begin
                if (model_count == 0) r.status = ST_EMPTY;
                else begin
                    model_count--;
                    r.value = model_stack[model_count];
                end
            end
            OP_RDT, OP_RDB: begin
                if (model_count == 0) r.status = ST_EMPTY;
                else if (pos >= model_count) r.status = ST_RANGE;
                else if (op == OP_RDT) r.value = model_stack[model_count - 1 - pos];
                else r.value = model_stack[pos];
            end
            default: begin
                if (model_count < 2) r.status = ST_FEW;
                else begin
                    x = model_stack[model_count - 1];
                    y = model_stack[model_count - 2];
                    model_count -= 2;
                    case (op)
                        OP_ADD: r.value = y + x;
                        OP_SUB: r.value = y - x;
                        OP_MUL: r.value = y * x;
                        default: begin
                            if (x == 0) r.status = ST_DIV0;
                            else r.value = floor_div(y, x);
                        end
                    endcase
                    if (r.status == ST_OK) begin
                        model_stack[model_count] = r.value;
                        model_count++;
                    end
                end
            end
        endcase
        if (r.status != ST_OK || op == OP_PUSH) r.value = '0;
        r.fill = model_count[CNT_W-1:0];
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    // send one word, predict at acceptance; valid stays up for a following word
    task automatic send_word(logic [OP_W-1:0] op, logic [WW-1:0] val, logic [POS_W-1:0] pos,
                             bit no_gap = 0);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_axis_tdata <= {{(IN_W - WW - 13){1'b0}}, pos, val, op};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        pending_results.push_back(calc_predict(op, val, pos));
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
    endtask

    // receiver stalls
    initial begin
        int g;
        @(negedge aclk);
        forever begin
            g = gap_len();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(negedge aclk);
        end
    end

    // result checker
    always @(posedge aclk) begin
        calc_result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.value = m_axis_tdata[WW-1:0];
            got.status = m_axis_tdata[WW+2:WW];
            got.fill = m_axis_tdata[WW+3+CNT_W-1:WW+3];
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: %h", m_axis_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                words_checked++;
                if (got.value !== want.value) begin
                    $error("result_value expected %h got %h", want.value, got.value);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, got.status);
                    errors++;
                end
                if (got.fill !== want.fill) begin
                    $error("fill_level expected %0d got %0d", want.fill, got.fill);
                    errors++;
                end
            end
        end
    end

    // empty-stack errors, extremes and every operation
    task automatic test_directed();
        send_word(OP_POP, '0, '0);
        send_word(OP_RDT, '0, '0);
        send_word(OP_RDB, '0, 10'h3FF);
        send_word(OP_ADD, '0, '0);
        send_word(OP_PUSH, 32'h8000_0000, '0);
        send_word(OP_DIV, '0, '0);
        send_word(OP_PUSH, 32'hFFFF_FFFF, '0);
        send_word(OP_RDT, '0, 10'd1);
        send_word(OP_RDB, '0, 10'd2);
        send_word(OP_RDT, '0, 10'h3FF);
        // most negative over minus one wraps
        send_word(OP_DIV, '0, '0);
        send_word(OP_PUSH, 32'h7FFF_FFFF, '0);
        send_word(OP_ADD, '0, '0);
        send_word(OP_PUSH, 32'd7, '0);
        send_word(OP_MUL, '0, '0);
        send_word(OP_PUSH, -32'sd7, '0);
        send_word(OP_PUSH, 32'd2, '0);
        send_word(OP_DIV, '0, '0);
        send_word(OP_SUB, '0, '0);
        send_word(OP_PUSH, 32'd0, '0);
        send_word(OP_DIV, '0, '0);
        send_word(OP_POP, '0, '0);
        send_word(OP_POP, '0, '0);
        drain();
    endtask

    // fill to full, push once more, read deep indices, then pop or combine top entries until at most 900 remain
    task automatic test_full_stack();
        while (model_count < DEPTH)
            send_word(OP_PUSH, $urandom, '0, $urandom_range(0, 7) != 0);
        send_word(OP_PUSH, $urandom, '0);
        send_word(OP_RDB, '0, 10'h3FF);
        send_word(OP_RDT, '0, 10'h3FF);
        send_word(OP_RDT, '0, 10'd0);
        while (model_count > 900) begin
            if ($urandom_range(0, 1)) send_word(OP_POP, '0, '0, 1);
            else send_word(OP_W'(OP_ADD + $urandom_range(0, 2)), '0, '0, 1);
        end
        drain();
    endtask

    function automatic logic [WW-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 4) - 2;
            1: return 32'h8000_0000 ^ $urandom_range(0, 1);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 1);
            3: return $urandom_range(0, 100);
            default: return $urandom;
        endcase
    endfunction

    // random mix weighted towards pushes, with pops, arithmetic and reads
    task automatic test_random(int n);
        logic [OP_W-1:0] op;
        logic [POS_W-1:0] pos;
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: op = OP_PUSH;
                4: op = OP_POP;
                5: op = OP_RDT;
                6: op = OP_RDB;
                default: op = OP_W'($urandom_range(OP_ADD, OP_DIV));
            endcase
            if ($urandom_range(0, 5) == 0 || model_count == 0) pos = POS_W'($urandom);
            else pos = POS_W'($urandom_range(0, model_count));
            send_word(op, rand_value(), pos);
            if ($urandom_range(0, 299) == 0) drain();
        end
        drain();
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_full_stack();
        test_random(400);
        $display("sent %0d command words, checked %0d result words", words_sent, words_checked);
        $display("covered empty, range, operand, divide-by-zero and full cases");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/stkc_pkg.sv
hw/rtl/stkc_ram.sv
hw/rtl/stkc_datapath.sv
hw/rtl/stkc_ctrl.sv
hw/rtl/stack_calculator.sv
tb/testbench.sv
